// File: sv/tccs_pkg.sv
// Shared types and constants for the text console with cursor and scroll.
// Depends on nothing; every other file of the block except tccs_ram refers to it by scoped names.
`timescale 1ns / 1ps

package tccs_pkg;

    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h0F;

    typedef struct packed {
        logic [1:0]        op;
        logic [CHAR_W-1:0] char_code;
        logic [4:0]        read_row;
        logic [6:0]        read_col;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_color;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_WRITE,
        CMD_BACKSPACE,
        CMD_NEWLINE,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [CHAR_W-1:0] ch;
        logic [4:0]        read_row;
        logic [6:0]        read_col;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_SCROLL,
        BK_CLEAR,
        BK_RESULT
    } t_back_state;

endpackage

// File: sv/tccs_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/tccs_front.sv
// Front end of the console: takes input transfers and sorts them into commands.
// Depends on tccs_pkg.
`timescale 1ns / 1ps

module tccs_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tccs_pkg::t_in_item i_in_data,
    input  logic              i_init_busy,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output tccs_pkg::t_cmd    o_cmd
);

    logic read_ok;

    // A read outside the screen changes nothing and returns zero cells.
    assign read_ok = (int'(i_in_data.read_row) < ROWS) && (int'(i_in_data.read_col) < COLUMNS);

    assign o_in_ready  = i_cmd_ready && !i_init_busy;
    assign o_cmd_valid = i_in_valid && !i_init_busy;

    always_comb begin
        o_cmd.ch       = i_in_data.char_code;
        o_cmd.read_row = i_in_data.read_row;
        o_cmd.read_col = i_in_data.read_col;
        case (i_in_data.op)
            tccs_pkg::OP_PUT: begin
                if (i_in_data.char_code == tccs_pkg::CH_NEWLINE) begin
                    o_cmd.kind = tccs_pkg::CMD_NEWLINE;
                end else if (i_in_data.char_code == tccs_pkg::CH_BACKSPACE) begin
                    o_cmd.kind = tccs_pkg::CMD_BACKSPACE;
                end else begin
                    o_cmd.kind = tccs_pkg::CMD_WRITE;
                end
            end
            tccs_pkg::OP_CLEAR: begin
                o_cmd.kind = tccs_pkg::CMD_CLEAR;
            end
            tccs_pkg::OP_READ: begin
                o_cmd.kind = read_ok ? tccs_pkg::CMD_READ : tccs_pkg::CMD_NOP;
            end
            default: begin
                o_cmd.kind = tccs_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

// File: sv/tccs_queue.sv
// Short command queue between the console front end and back end.
// Depends on tccs_pkg.
`timescale 1ns / 1ps

module tccs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  tccs_pkg::t_cmd i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output tccs_pkg::t_cmd o_pop_data
);

    localparam int PTR_W = (tccs_pkg::QUEUE_DEPTH > 1) ? $clog2(tccs_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tccs_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(tccs_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tccs_pkg::QUEUE_DEPTH - 1);

    tccs_pkg::t_cmd   r_slot [tccs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("command queue holds more entries than it has");

endmodule

// File: sv/tccs_back.sv
// Back end of the console: cursor, ring row offset, screen store and sweeps.
// Depends on tccs_pkg and tccs_ram.
`timescale 1ns / 1ps

module tccs_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  tccs_pkg::t_cmd       i_cmd,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tccs_pkg::t_out_item  o_out_data,
    output logic                 o_init_busy
);

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int MEM_DEPTH = ROWS * (2 ** COL_W);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W:0]   ROWS_EXT = (ROW_W + 1)'(ROWS);

    tccs_pkg::t_back_state r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_top, n_top;
    logic [ROW_W-1:0]  r_swp_row, n_swp_row;
    logic [COL_W-1:0]  r_swp_col, n_swp_col;
    logic [7:0]        r_attr;
    logic              r_is_read, n_is_read;
    logic              r_out_valid, n_out_valid;
    tccs_pkg::t_out_item r_out_data, n_out_data;

    logic                          mem_we;
    logic                          mem_re;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [ADDR_W-1:0]             mem_raddr;
    logic [tccs_pkg::CELL_W-1:0]   mem_wdata;
    logic [tccs_pkg::CELL_W-1:0]   mem_rdata;

    logic [ROW_W-1:0] cur_phys;
    logic [ROW_W-1:0] rd_phys;
    logic [ROW_W-1:0] top_next;
    logic [ROW_W-1:0] bottom_phys;
    logic             wrap_needed;
    logic             scroll_needed;
    logic             sweep_done;
    logic             out_free;
    logic [31:0]      pos_full;

    // Logical row to physical row of the ring: (top + row) mod ROWS.
    function automatic logic [ROW_W-1:0] ring_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] row);
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (sum >= ROWS_EXT) begin
            sum = sum - ROWS_EXT;
        end
        return sum[ROW_W-1:0];
    endfunction

    assign cur_phys    = ring_row(r_top, r_row);
    assign rd_phys     = ring_row(r_top, ROW_W'(i_cmd.read_row));
    assign top_next    = ring_row(r_top, ROW_W'(1));
    assign bottom_phys = ring_row(r_top, LAST_ROW);
    assign wrap_needed = (i_cmd.kind == tccs_pkg::CMD_NEWLINE) ||
                         ((i_cmd.kind == tccs_pkg::CMD_WRITE) && (r_col == LAST_COL));
    assign scroll_needed = wrap_needed && (r_row == LAST_ROW);
    assign sweep_done  = (r_swp_row == LAST_ROW) && (r_swp_col == LAST_COL);
    assign out_free    = !r_out_valid || i_out_ready;
    assign pos_full    = 32'(r_row) * 32'(COLUMNS) + 32'(r_col);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tccs_pkg::BK_INIT: begin
                if (sweep_done) begin
                    n_state = tccs_pkg::BK_IDLE;
                end
            end
            tccs_pkg::BK_CLEAR: begin
                if (sweep_done) begin
                    n_state = tccs_pkg::BK_RESULT;
                end
            end
            tccs_pkg::BK_SCROLL: begin
                if (r_swp_col == LAST_COL) begin
                    n_state = tccs_pkg::BK_RESULT;
                end
            end
            tccs_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == tccs_pkg::CMD_CLEAR) begin
                        n_state = tccs_pkg::BK_CLEAR;
                    end else if (scroll_needed) begin
                        n_state = tccs_pkg::BK_SCROLL;
                    end else begin
                        n_state = tccs_pkg::BK_RESULT;
                    end
                end
            end
            tccs_pkg::BK_RESULT: begin
                if (out_free) begin
                    n_state = tccs_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = tccs_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        n_row       = r_row;
        n_col       = r_col;
        n_top       = r_top;
        n_swp_row   = r_swp_row;
        n_swp_col   = r_swp_col;
        n_is_read   = r_is_read;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        o_cmd_ready = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = {cur_phys, r_col};
        mem_raddr   = {rd_phys, COL_W'(i_cmd.read_col)};
        mem_wdata   = {r_attr, tccs_pkg::CH_SPACE};
        case (r_state)
            tccs_pkg::BK_INIT, tccs_pkg::BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_swp_row, r_swp_col};
                mem_wdata = (r_state == tccs_pkg::BK_INIT) ?
                            {tccs_pkg::RESET_COLOR, tccs_pkg::CH_SPACE} :
                            {r_attr, tccs_pkg::CH_SPACE};
                if (r_swp_col == LAST_COL) begin
                    n_swp_col = '0;
                    n_swp_row = r_swp_row + ROW_W'(1);
                end else begin
                    n_swp_col = r_swp_col + COL_W'(1);
                end
            end
            tccs_pkg::BK_SCROLL: begin
                mem_we    = 1'b1;
                mem_waddr = {r_swp_row, r_swp_col};
                n_swp_col = r_swp_col + COL_W'(1);
            end
            tccs_pkg::BK_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_is_read = 1'b0;
                    case (i_cmd.kind)
                        tccs_pkg::CMD_WRITE: begin
                            mem_we    = 1'b1;
                            mem_wdata = {r_attr, i_cmd.ch};
                            n_col     = r_col + COL_W'(1);
                        end
                        tccs_pkg::CMD_BACKSPACE: begin
                            if (r_col != '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = {cur_phys, r_col - COL_W'(1)};
                                n_col     = r_col - COL_W'(1);
                            end
                        end
                        tccs_pkg::CMD_CLEAR: begin
                            n_row     = '0;
                            n_col     = '0;
                            n_top     = '0;
                            n_swp_row = '0;
                            n_swp_col = '0;
                        end
                        tccs_pkg::CMD_READ: begin
                            mem_re    = 1'b1;
                            n_is_read = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    if (wrap_needed) begin
                        n_col = '0;
                        if (scroll_needed) begin
                            // The top row of the ring becomes the new bottom row.
                            n_top     = top_next;
                            n_swp_row = r_top;
                            n_swp_col = '0;
                        end else begin
                            n_row = r_row + ROW_W'(1);
                        end
                    end
                end
            end
            tccs_pkg::BK_RESULT: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_data.cursor_pos = pos_full[tccs_pkg::POS_W-1:0];
                    n_out_data.cell_char  = r_is_read ? mem_rdata[7:0] : '0;
                    n_out_data.cell_color = r_is_read ? mem_rdata[15:8] : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tccs_pkg::BK_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_swp_row   <= '0;
            r_swp_col   <= '0;
            r_attr      <= tccs_pkg::RESET_COLOR;
            r_is_read   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_top       <= n_top;
            r_swp_row   <= n_swp_row;
            r_swp_col   <= n_swp_col;
            r_is_read   <= n_is_read;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    tccs_ram #(
        .WIDTH (tccs_pkg::CELL_W),
        .DEPTH (MEM_DEPTH)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_init_busy = (r_state == tccs_pkg::BK_INIT);

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= LAST_ROW) && (r_col <= LAST_COL))
        else $error("cursor left the screen");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= LAST_ROW)
        else $error("ring row offset out of range");

    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tccs_pkg::BK_SCROLL) |-> (r_swp_row == bottom_phys))
        else $error("scroll blanks a row other than the bottom row");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == tccs_pkg::BK_RESULT))
        else $error("result loaded outside the result state");

endmodule

// File: sv/text_console_cursor_scroll.sv
// Top level of the text-mode console with cursor and scrolling.
// Depends on tccs_pkg, tccs_front, tccs_queue, tccs_back and tccs_ram.
`timescale 1ns / 1ps

// Text-mode console of COLUMNS x ROWS cells (80 x 25 by default). Each input
// transfer is a put-character, clear-screen or read-cell command, and each one
// yields exactly one output transfer carrying the linear cursor position and,
// for an in-range read, the cell's character and color bytes. After reset the
// block writes spaces in color 0x0F to the whole screen store; o_in_ready
// stays low during that pass, while color register writes are taken as usual.
// Afterwards, for a printable character, backspace, newline without scroll,
// read or unused op, the back end first updates the cursor and writes or reads
// the screen RAM, then loads the output register once that register is free.
// A newline or column wrap on the last row advances a ring row offset and then
// blanks the new bottom row one cell a cycle. A clear sweeps every cell, one a
// cycle. A two-entry command queue sits between the classifying front end and
// the back end, so input keeps being taken, until the queue is full, while a
// finished result waits in the output register.
module text_console_cursor_scroll #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tccs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tccs_pkg::t_out_item o_out_data
);

    logic           front_valid;
    logic           queue_ready;
    tccs_pkg::t_cmd front_cmd;
    logic           back_valid;
    logic           back_ready;
    tccs_pkg::t_cmd back_cmd;
    logic           init_busy;

    // The front end only decodes; it holds off input while the reset clear runs.
    tccs_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_init_busy (init_busy),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (queue_ready),
        .o_cmd       (front_cmd)
    );

    tccs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (queue_ready),
        .i_push_data  (front_cmd),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_cmd)
    );

    // The back end owns the console state: cursor, ring offset, color and screen RAM.
    tccs_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (back_valid),
        .o_cmd_ready (back_ready),
        .i_cmd       (back_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_init_busy (init_busy)
    );

endmodule
